>>> src/p3dh_pkg.sv
// Package for the periodic 3-D density histogram.
// Holds item kind codes, the sequencer state type and fixed sizes; no dependencies.
`default_nettype none
package p3dh_pkg;
	typedef enum logic [1:0] {
		KIND_PARTICLE = 2'd0,
		KIND_FRAME    = 2'd1,
		KIND_READ     = 2'd2,
		KIND_NONE     = 2'd3
	} kind_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WRAP,
		ST_BIN,
		ST_RMW,
		ST_WRITE,
		ST_FRAME,
		ST_RDIV,
		ST_RCEN,
		ST_OUT
	} state_t;

	// Bins per axis; a power of two so bin indices concatenate into an address.
	localparam int unsigned BINS      = 64;
	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned MEAN_W    = 48;
	localparam int unsigned POS_W     = 32;
	localparam int unsigned LEN_W     = 31;
	localparam int unsigned IDX_OUT_W = 6;
endpackage
`default_nettype wire

>>> src/p3dh_ram.sv
// Generic single-port-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module p3dh_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> src/p3dh_div.sv
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on nothing; used for wrap, bin and mean quotients.
`default_nettype none
module p3dh_div #(
	parameter int unsigned NW = 64,
	parameter int unsigned DW = 40
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               busy,
	output logic [NW-1:0]      quo
);
	localparam int unsigned CW = $clog2(NW + 1);
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [NW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   trial;
	logic [DW+1:0] shifted;

	assign shifted = {rem_q, n_q[NW-1]};
	assign trial   = shifted[DW:0] - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			n_q   <= num;
			d_q   <= den;
			quo   <= '0;
		end else if (cnt_q != '0) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			// Remainder stays below the divisor, so one extra bit is enough.
			if (!trial[DW] || shifted[DW+1]) begin
				rem_q <= trial;
				quo   <= {quo[NW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW:0];
				quo   <= {quo[NW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
endmodule
`default_nettype wire

>>> src/periodic_3d_density_histogram.sv
// Periodic 3-D density histogram, top level.
// Uses p3dh_pkg, p3dh_ram (count store) and p3dh_div (shared divider).
//
//  channel   signals                                   role
//  in        in_valid/in_ready, kind..box_len_z        request: particle, frame, readout
//  out       out_valid/out_ready, bin_i..last_bin      readout result
//  cfg       cfg_we, cfg_data                          selected_type register
//
// After acceptance a counted particle runs the shared serial divider twice per axis
// (wrap quotient, then bin quotient), then a read-modify-write (ST_RMW, ST_WRITE). A
// readout does a mean divide, computes one centre per axis, then loads the result register,
// later while a previous result waits; a frame passes through ST_FRAME, other requests
// leave the sequencer in ST_IDLE.
// After reset a clearing pass writes zero to all 262144 entries, one per cycle,
// before the first request is accepted. The result register frees the input side.
`default_nettype none
module periodic_3d_density_histogram
	import p3dh_pkg::*;
#(
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           kind,
	input  wire logic signed [31:0]   pos_x,
	input  wire logic signed [31:0]   pos_y,
	input  wire logic signed [31:0]   pos_z,
	input  wire logic [7:0]           particle_type,
	input  wire logic [30:0]          box_len_x,
	input  wire logic [30:0]          box_len_y,
	input  wire logic [30:0]          box_len_z,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [5:0]                bin_i,
	output logic [5:0]                bin_j,
	output logic [5:0]                bin_k,
	output logic signed [31:0]        center_x,
	output logic signed [31:0]        center_y,
	output logic signed [31:0]        center_z,
	output logic [47:0]               mean_count,
	output logic                      last_bin,
	input  wire logic                 cfg_we,
	input  wire logic [7:0]           cfg_data
);
	localparam int unsigned IW    = $clog2(BINS);
	localparam int unsigned AW    = 3 * IW;
	localparam int unsigned CELLS = BINS * BINS * BINS;
	localparam int unsigned NW    = 64;
	localparam int unsigned DW    = 40;
	localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

	state_t state_q, state_d;

	logic [7:0]         sel_q;
	logic [31:0]        frames_q;
	logic [LEN_W-1:0]   len_q [3];
	logic [AW-1:0]      ptr_q;
	logic [AW-1:0]      clr_q;
	logic [1:0]         axis_q;
	logic signed [POS_W-1:0] pos_q [3];
	logic [IW-1:0]      idx_q [3];
	logic [AW-1:0]      addr_q;
	logic               pend_q;
	logic [MEAN_W-1:0]  mean_q;
	logic signed [POS_W-1:0] cen_q [3];

	// Divider interface.
	logic               div_start;
	logic [NW-1:0]      div_num;
	logic [DW-1:0]      div_den;
	logic               div_busy;
	logic [NW-1:0]      div_quo;
	logic               div_go_q;

	// RAM.
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [COUNT_WIDTH-1:0] ram_wdata;
	logic [AW-1:0]          ram_raddr;
	logic [COUNT_WIDTH-1:0] ram_rdata;

	logic acc;
	logic out_free;
	logic out_load;

	assign out_free = !out_valid || out_ready;
	assign out_load = (state_q == ST_OUT) && out_free;
	assign in_ready = (state_q == ST_IDLE);
	assign acc      = in_valid && in_ready;

	// Current axis values.
	logic signed [POS_W-1:0] cur_pos;
	logic [LEN_W-1:0]        cur_len;
	logic [IW-1:0]           cur_idx;
	assign cur_pos = pos_q[axis_q];
	assign cur_len = len_q[axis_q];
	assign cur_idx = idx_q[axis_q];

	logic [POS_W-1:0] abs_pos;
	assign abs_pos = cur_pos[POS_W-1] ? POS_W'(-cur_pos) : cur_pos;

	// Wrapped coordinate from the wrap quotient n (n <= 2^32/len + 1).
	logic signed [NW-1:0] nl_prod;
	logic signed [NW-1:0] wrapped;
	logic [NW-1:0]        wabs;
	logic [NW-1:0]        wabs_q;
	assign nl_prod = signed'(NW'(div_quo[32:0]) * NW'(cur_len));
	assign wrapped = cur_pos[POS_W-1] ? NW'(cur_pos) + nl_prod : NW'(cur_pos) - nl_prod;
	assign wabs    = wrapped[NW-1] ? -wrapped : wrapped;

	// Bin index from bin quotient: floor toward negative via ceil of magnitude.
	logic signed [NW-1:0] q_signed;
	logic signed [NW-1:0] q_off;
	logic                 wneg_q;
	assign q_signed = wneg_q ? -signed'(div_quo) : signed'(div_quo);
	assign q_off    = q_signed + NW'(BINS / 2);
	logic [IW-1:0] clamped;
	always_comb begin
		if (q_off < 0) begin
			clamped = '0;
		end else if (q_off > NW'(BINS - 1)) begin
			clamped = IW'(BINS - 1);
		end else begin
			clamped = q_off[IW-1:0];
		end
	end

	// Centre: num = (2*idx - BINS + 1)*len, q = (2|num| + 2B) / 4B, a shift.
	logic signed [NW-1:0] cen_num;
	logic [NW-1:0]        cen_abs;
	logic [NW-1:0]        cen_rnd;
	assign cen_num = (NW'(2 * cur_idx) - NW'(BINS) + 1) * signed'(NW'(cur_len));
	assign cen_abs = cen_num[NW-1] ? -cen_num : cen_num;
	assign cen_rnd = ((cen_abs << 1) + NW'(2 * BINS)) >> (IW + 2);

	logic [31:0] cen_val;
	assign cen_val = cen_num[NW-1] ? 32'(-cen_rnd) : cen_rnd[31:0];

	logic [AW-1:0] cell_addr;
	assign cell_addr = {idx_q[0], idx_q[1], idx_q[2]};

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = addr_q;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == AW'(CELLS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (acc) begin
					case (kind)
						KIND_PARTICLE: begin
							if (particle_type == sel_q) begin
								state_d = ST_WRAP;
							end
						end
						KIND_FRAME: state_d = ST_FRAME;
						KIND_READ: state_d = ST_RDIV;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_WRAP: begin
				if (!div_go_q) begin
					div_start = 1'b1;
					div_num   = NW'({abs_pos, 1'b0}) + NW'(cur_len);
					div_den   = DW'({cur_len, 1'b0});
				end else if (!div_busy) begin
					state_d = ST_BIN;
				end
			end
			ST_BIN: begin
				if (!div_go_q) begin
					div_start = 1'b1;
					div_num   = wneg_q ? wabs_q * NW'(BINS) + NW'(cur_len) - NW'(1)
					                   : wabs_q * NW'(BINS);
					div_den   = DW'(cur_len);
				end else if (!div_busy) begin
					state_d = (axis_q == 2'd2) ? ST_RMW : ST_WRAP;
				end
			end
			ST_RMW: begin
				ram_raddr = cell_addr;
				state_d   = ST_WRITE;
			end
			ST_WRITE: begin
				ram_we    = (ram_rdata != CMAX);
				ram_wdata = ram_rdata + 1'b1;
				state_d   = ST_IDLE;
			end
			ST_FRAME: state_d = ST_IDLE;
			ST_RDIV: begin
				ram_raddr = ptr_q;
				if (!div_go_q) begin
					div_start = 1'b1;
					div_num   = NW'(ram_rdata) << FRAC_BITS;
					div_den   = DW'(frames_q);
				end else if (!div_busy) begin
					state_d = ST_RCEN;
				end
			end
			ST_RCEN: begin
				if (axis_q == 2'd2) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			sel_q     <= 8'd1;
			frames_q  <= '0;
			len_q[0]  <= LEN_W'(1);
			len_q[1]  <= LEN_W'(1);
			len_q[2]  <= LEN_W'(1);
			ptr_q     <= '0;
			axis_q    <= '0;
			div_go_q  <= 1'b0;
			out_valid <= 1'b0;
			pend_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				sel_q <= cfg_data;
			end
			out_valid <= out_load || (out_valid && !out_ready);
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: begin
					axis_q   <= '0;
					div_go_q <= 1'b0;
					pend_q   <= 1'b0;
					if (acc && kind == KIND_FRAME) begin
						len_q[0] <= (box_len_x == '0) ? LEN_W'(1) : box_len_x;
						len_q[1] <= (box_len_y == '0) ? LEN_W'(1) : box_len_y;
						len_q[2] <= (box_len_z == '0) ? LEN_W'(1) : box_len_z;
						if (frames_q != '1) begin
							frames_q <= frames_q + 1'b1;
						end
					end
				end
				ST_WRAP: begin
					if (!div_go_q) begin
						div_go_q <= 1'b1;
					end else if (!div_busy) begin
						div_go_q <= 1'b0;
					end
				end
				ST_BIN: begin
					if (!div_go_q) begin
						div_go_q <= 1'b1;
					end else if (!div_busy) begin
						div_go_q <= 1'b0;
						axis_q   <= axis_q + 1'b1;
					end
				end
				ST_RDIV: begin
					// The pend_q step lets the registered read settle before the divide.
					if (!pend_q) begin
						pend_q <= 1'b1;
					end else if (!div_go_q) begin
						div_go_q <= 1'b1;
					end else if (!div_busy) begin
						div_go_q <= 1'b0;
					end
				end
				ST_RCEN: axis_q <= axis_q + 1'b1;
				ST_OUT: begin
					if (out_free) begin
						ptr_q <= (ptr_q == AW'(CELLS - 1)) ? '0 : ptr_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Divider start in ST_RDIV waits for the read to settle.
	logic div_start_g;
	assign div_start_g = div_start && !(state_q == ST_RDIV && !pend_q);

	always_ff @(posedge clk) begin
		if (acc && kind == KIND_PARTICLE) begin
			pos_q[0] <= pos_x;
			pos_q[1] <= pos_y;
			pos_q[2] <= pos_z;
		end
		if (state_q == ST_WRAP && div_go_q && !div_busy) begin
			wneg_q <= wrapped[NW-1];
			wabs_q <= wabs;
		end
		if (state_q == ST_BIN && div_go_q && !div_busy) begin
			idx_q[axis_q] <= clamped;
		end
		if (state_q == ST_RMW) begin
			addr_q <= cell_addr;
		end
		if (state_q == ST_IDLE && acc && kind == KIND_READ) begin
			idx_q[0] <= ptr_q[AW-1 -: IW];
			idx_q[1] <= ptr_q[IW +: IW];
			idx_q[2] <= ptr_q[IW-1:0];
			addr_q   <= ptr_q;
		end
		if (state_q == ST_RDIV && div_go_q && !div_busy) begin
			mean_q <= (frames_q == '0) ? '0
			        : ((div_quo > NW'({MEAN_W{1'b1}})) ? '1 : div_quo[MEAN_W-1:0]);
		end
		if (state_q == ST_RCEN) begin
			cen_q[axis_q] <= cen_val;
		end
		if (out_load) begin
			bin_i      <= IDX_OUT_W'(idx_q[0]);
			bin_j      <= IDX_OUT_W'(idx_q[1]);
			bin_k      <= IDX_OUT_W'(idx_q[2]);
			center_x   <= cen_q[0];
			center_y   <= cen_q[1];
			center_z   <= cen_q[2];
			mean_count <= mean_q;
			last_bin   <= (ptr_q == AW'(CELLS - 1));
		end
	end

	p3dh_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(CELLS)
	) u_count_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	p3dh_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start_g),
		.num   (div_num),
		.den   ((div_den == '0) ? DW'(1) : div_den),
		.busy  (div_busy),
		.quo   (div_quo)
	);
endmodule
`default_nettype wire

>>> src/p3dh_checker.sv
// Port-level checks for the periodic 3-D density histogram.
// Bound to periodic_3d_density_histogram; no package needed.
`default_nettype none
module p3dh_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [5:0] bin_k,
	input wire logic       last_bin,
	input wire logic [47:0] mean_count
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_count) && $stable(bin_k)
			&& $stable(last_bin))
		else $error("result dropped or changed while stalled");
	a_ready_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(in_ready) && !$isunknown(out_valid))
		else $error("handshake output unknown");
	a_last_k: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_bin |-> bin_k == 6'h3f)
		else $error("last bin index inconsistent");
endmodule

bind periodic_3d_density_histogram p3dh_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .bin_k(bin_k),
	.last_bin(last_bin), .mean_count(mean_count)
);
`default_nettype wire

>>> sim/tb.sv
// Testbench for periodic_3d_density_histogram: directed table, then random phases.
// Depends on p3dh_pkg and the block; an in-bench predictor or the directed table checks every readout result.
`timescale 1ns / 1ps
module tb;
	import p3dh_pkg::*;

	localparam int NBINS       = 64;
	localparam int WATCH_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 600;
	localparam int PHASE_ITEMS = 350;

	typedef struct {
		kind_t              kind;
		logic signed [31:0] px, py, pz;
		logic [7:0]         ptype;
		logic [30:0]        bx, by, bz;
	} request_t;

	typedef struct {
		logic [5:0]         i, j, k;
		logic signed [31:0] cx, cy, cz;
		logic [47:0]        mean;
		logic               last;
	} bin_result_t;

	typedef struct {
		request_t    req;
		bit          typed;
		bin_result_t res;
	} table_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, in_ready;
	logic [1:0] kind = 0;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic [7:0] particle_type = 0;
	logic [30:0] box_len_x = 0, box_len_y = 0, box_len_z = 0;
	logic out_valid, out_ready = 0;
	logic [5:0] bin_i, bin_j, bin_k;
	logic signed [31:0] center_x, center_y, center_z;
	logic [47:0] mean_count;
	logic last_bin;
	logic cfg_we = 0;
	logic [7:0] cfg_data = 0;

	// Predictor state.
	int unsigned bin_counts [int unsigned];
	int unsigned frames_seen = 0;
	longint box_len [3] = '{1, 1, 1};
	int unsigned read_ptr = 0;
	logic [7:0] sel_type = 8'd1;

	bin_result_t pending_bins [$];
	int errors = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int quiet_cycles = 0;
	table_row_t rows [20];

	periodic_3d_density_histogram uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .kind(kind),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .particle_type(particle_type),
		.box_len_x(box_len_x), .box_len_y(box_len_y), .box_len_z(box_len_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.bin_i(bin_i), .bin_j(bin_j), .bin_k(bin_k),
		.center_x(center_x), .center_y(center_y), .center_z(center_z),
		.mean_count(mean_count), .last_bin(last_bin),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	function automatic int unsigned axis_bin(longint x, longint len);
		longint ax, n, w, num, q;
		ax = (x < 0) ? -x : x;
		n = (2 * ax + len) / (2 * len);
		w = (x < 0) ? x + n * len : x - n * len;
		num = w * NBINS;
		if (num >= 0) begin
			q = num / len;
		end else begin
			q = -((-num + len - 1) / len);
		end
		q += NBINS / 2;
		if (q < 0) q = 0;
		if (q > NBINS - 1) q = NBINS - 1;
		return int'(q);
	endfunction

	function automatic logic [31:0] bin_centre(int unsigned idx, longint len);
		longint num, an, q;
		num = (2 * longint'(idx) - NBINS + 1) * len;
		an = (num < 0) ? -num : num;
		q = (2 * an + 2 * NBINS) / (4 * NBINS);
		return (num < 0) ? 32'(-q) : 32'(q);
	endfunction

	// Applies one accepted request to the model; returns 1 when a readout result follows.
	function automatic bit histogram_step(request_t r, output bin_result_t res);
		int unsigned bin_addr, p;
		longint unsigned cnt, mean;
		logic [30:0] lens [3];
		res = '{default: '0};
		case (r.kind)
			KIND_PARTICLE: begin
				if (r.ptype == sel_type) begin
					bin_addr = (axis_bin(r.px, box_len[0]) * NBINS
						+ axis_bin(r.py, box_len[1])) * NBINS + axis_bin(r.pz, box_len[2]);
					if (!bin_counts.exists(bin_addr)) bin_counts[bin_addr] = 0;
					if (bin_counts[bin_addr] != 32'hFFFF_FFFF) bin_counts[bin_addr]++;
				end
				return 0;
			end
			KIND_FRAME: begin
				lens = '{r.bx, r.by, r.bz};
				for (int a = 0; a < 3; a++) box_len[a] = (lens[a] == 0) ? 1 : longint'(lens[a]);
				if (frames_seen != 32'hFFFF_FFFF) frames_seen++;
				return 0;
			end
			KIND_READ: begin
				p = read_ptr;
				cnt = bin_counts.exists(p) ? bin_counts[p] : 0;
				mean = 0;
				if (frames_seen != 0) begin
					mean = (cnt << 16) / frames_seen;
					if (mean > 48'hFFFF_FFFF_FFFF) mean = 48'hFFFF_FFFF_FFFF;
				end
				res.k = 6'(p % NBINS);
				res.j = 6'((p / NBINS) % NBINS);
				res.i = 6'(p / (NBINS * NBINS));
				res.cx = bin_centre(p / (NBINS * NBINS), box_len[0]);
				res.cy = bin_centre((p / NBINS) % NBINS, box_len[1]);
				res.cz = bin_centre(p % NBINS, box_len[2]);
				res.mean = 48'(mean);
				res.last = (p == NBINS * NBINS * NBINS - 1);
				read_ptr = (p + 1 >= NBINS * NBINS * NBINS) ? 0 : p + 1;
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// Sends one request, idling first as the current phase asks.
	task automatic send_request(request_t r, bit typed, bin_result_t typed_res);
		bin_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= r.kind;
		pos_x <= r.px; pos_y <= r.py; pos_z <= r.pz;
		particle_type <= r.ptype;
		box_len_x <= r.bx; box_len_y <= r.by; box_len_z <= r.bz;
		do @(posedge clk); while (!in_ready);
		if (histogram_step(r, res)) pending_bins.push_back(typed ? typed_res : res);
	endtask

	task automatic write_sel_type(logic [7:0] v);
		in_valid <= 0;
		wait (pending_bins.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		sel_type = v;
	endtask

	// Places a coordinate in the first span_bins bins of an axis, sometimes shifted by whole periods.
	function automatic logic [31:0] low_corner(longint len, int span_bins);
		longint v, shifted;
		v = -(len / 2) + longint'($urandom_range(0, 32'(len * span_bins / NBINS)));
		shifted = v + longint'($urandom_range(0, 4)) * len - 2 * len;
		if (shifted >= -64'sd2147483648 && shifted <= 64'sd2147483647) v = shifted;
		return 32'(v);
	endfunction

	function automatic request_t random_request();
		request_t r;
		int pick;
		longint len;
		r.px = $urandom; r.py = $urandom; r.pz = $urandom;
		r.ptype = 8'($urandom);
		r.bx = 31'($urandom); r.by = 31'($urandom); r.bz = 31'($urandom);
		pick = $urandom_range(99);
		if (pick < 60) begin
			r.kind = KIND_PARTICLE;
			if ($urandom_range(99) < 80) r.ptype = sel_type;
			if ($urandom_range(99) < 65) begin
				r.px = low_corner(box_len[0], 1);
				r.py = low_corner(box_len[1], 4);
				r.pz = low_corner(box_len[2], 32);
			end
		end else if (pick < 70) begin
			r.kind = KIND_FRAME;
			if ($urandom_range(99) < 80) begin
				len = $urandom_range(32'h0001_0000, 32'h0400_0000);
				r.bx = 31'(len);
				r.by = 31'(len + $urandom_range(0, 5000));
				r.bz = 31'(len - $urandom_range(0, 5000));
			end else if ($urandom_range(9) == 0) begin
				r.by = 0;
			end
		end else if (pick < 97) begin
			r.kind = KIND_READ;
		end else begin
			r.kind = KIND_NONE;
		end
		return r;
	endfunction

	function automatic table_row_t mk_row(kind_t k, logic [31:0] p, logic [7:0] t,
			logic [30:0] b, bit typed, logic [5:0] bk);
		table_row_t row;
		row.req = '{kind: k, px: p, py: p, pz: p, ptype: t, bx: b, by: b, bz: b};
		row.typed = typed;
		row.res = '{default: '0};
		row.res.k = bk;
		return row;
	endfunction

	always @(posedge clk) begin
		bin_result_t want;
		if (out_valid && out_ready) begin
			if (pending_bins.size() == 0) begin
				$display("unexpected result at %0t", $realtime);
				errors++;
			end else begin
				want = pending_bins.pop_front();
				if (bin_i !== want.i) report_mismatch("bin_i", bin_i, want.i);
				if (bin_j !== want.j) report_mismatch("bin_j", bin_j, want.j);
				if (bin_k !== want.k) report_mismatch("bin_k", bin_k, want.k);
				if (center_x !== want.cx) report_mismatch("center_x", center_x, want.cx);
				if (center_y !== want.cy) report_mismatch("center_y", center_y, want.cy);
				if (center_z !== want.cz) report_mismatch("center_z", center_z, want.cz);
				if (mean_count !== want.mean) report_mismatch("mean_count", mean_count, want.mean);
				if (last_bin !== want.last) report_mismatch("last_bin", last_bin, want.last);
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCH_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [7:0] phase_types [4];
		bin_result_t unused;
		unused = '{default: '0};
		phase_types = '{8'd0, 8'd255, 8'd1, 8'($urandom)};

		rows[0]  = mk_row(KIND_READ, 0, 0, 0, 1, 6'd0);
		rows[1]  = mk_row(KIND_READ, 0, 0, 0, 1, 6'd1);
		rows[2]  = mk_row(KIND_FRAME, 0, 0, 31'd0, 0, 0);
		rows[3]  = mk_row(KIND_READ, 0, 0, 0, 1, 6'd2);
		rows[4]  = mk_row(KIND_PARTICLE, 32'h8000_0000, 8'd1, 0, 0, 0);
		rows[5]  = mk_row(KIND_PARTICLE, 32'h7FFF_FFFF, 8'd1, 0, 0, 0);
		rows[6]  = mk_row(KIND_PARTICLE, 0, 8'd0, 0, 0, 0);
		rows[7]  = mk_row(KIND_NONE, 32'hFFFF_FFFF, 8'hFF, 31'h7FFF_FFFF, 0, 0);
		rows[8]  = mk_row(KIND_FRAME, 0, 0, 31'h7FFF_FFFF, 0, 0);
		rows[9]  = mk_row(KIND_PARTICLE, 32'h8000_0000, 8'd1, 0, 0, 0);
		rows[10] = mk_row(KIND_PARTICLE, 32'h7FFF_FFFF, 8'd1, 0, 0, 0);
		rows[11] = mk_row(KIND_PARTICLE, 0, 8'd1, 0, 0, 0);
		rows[12] = mk_row(KIND_FRAME, 0, 0, 31'h0010_0000, 0, 0);
		rows[13] = mk_row(KIND_PARTICLE, -32'sd524278, 8'd1, 0, 0, 0);
		rows[13].req.pz = -32'sd524288 + 3 * 16384 + 5;
		rows[14] = rows[13];
		rows[15] = mk_row(KIND_PARTICLE, -32'sd524278, 8'd255, 0, 0, 0);
		for (int n = 16; n < 20; n++) rows[n] = mk_row(KIND_READ, 0, 0, 0, 0, 0);

		repeat (4) @(posedge clk);
		arst_n <= 1;

		foreach (rows[n]) send_request(rows[n].req, rows[n].typed, rows[n].res);

		for (int ph = 0; ph < 4; ph++) begin
			write_sel_type(phase_types[ph]);
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				default: begin send_idle_pct = 30; recv_stall_pct = 30; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request(), 0, unused);
		end

		in_valid <= 0;
		wait (pending_bins.size() == 0);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
